// ===== sv/htw_pkg.sv =====
package htw_pkg;

  localparam int NumBucketsDef = 16;
  localparam int NumSlotsDef = 64;
  localparam int KeyW = 32;
  localparam int LinkW = 7;
  localparam logic [LinkW-1:0] NilLink = 7'd127;

  typedef enum logic [1:0] {
    ACT_SCHED  = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_SCHED  = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_FIRED  = 3'd2,
    KIND_TIME   = 3'd3,
    KIND_IDLE   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_NOTQ   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  event_id;
    logic [23:0] delay;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  fired_id;
    logic [23:0] remaining;
    logic [1:0]  status;
    logic        last;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_WALK_RD,
    S_WALK,
    S_INS_NRD,
    S_INS_FIX,
    S_INS_LNK,
    S_UNL_RD,
    S_UNL_FIX,
    S_TICK_HD,
    S_TICK_KEY,
    S_DONE
  } state_t;

  function automatic logic key_before(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    logic [KeyW-1:0] d;
    d = a - b;
    return d[KeyW-1];
  endfunction

endpackage

// ===== sv/hashed_timer_wheel_sorted_buckets.sv =====
// Hashed timing wheel timer scheduler with sorted buckets.
// Raise start with a request on in_req; it is taken at the first edge where
// busy is low. Actions: schedule, cancel, tick, query remaining time.
// Results appear on out_res, each for exactly one cycle with out_valid high;
// the last result of a request has last set. The receiver cannot stall.
// Event keys and prev/next links live in synchronous memories with registered
// reads; bucket head/tail tables and queued flags are flip-flops.
// A query and any rejected request finish without touching the lists; a cancel
// unlinks its event; a schedule into an empty bucket needs no walk, else it
// walks the bucket from the tail, comparing keys; a tick fires due events from
// the head and stops at an empty bucket or at a head that is not yet due.
// Busy falls in the cycle that carries the last result, and the next request
// can be taken at the edge that ends it; no request is taken before that.
// Reset clears the pulse counter, all queued flags and all bucket heads and
// tails at once; no clearing pass is needed and start is taken right after.
module hashed_timer_wheel_sorted_buckets #(
  parameter int NUM_BUCKETS = htw_pkg::NumBucketsDef,
  parameter int NUM_SLOTS = htw_pkg::NumSlotsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  htw_pkg::in_req_t  in_req,
  output logic              out_valid,
  output htw_pkg::out_res_t out_res
);
  import htw_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [KeyW-1:0]  key_mem  [NUM_SLOTS];
  logic [LinkW-1:0] next_mem [NUM_SLOTS];
  logic [LinkW-1:0] prev_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] queued_r, queued_nxt;
  logic [LinkW-1:0] head_r [NUM_BUCKETS];
  logic [LinkW-1:0] tail_r [NUM_BUCKETS];

  state_t state_r, state_nxt;
  logic [KeyW-1:0] pulse_r, pulse_nxt;
  in_req_t req_r, req_nxt;
  logic [KeyW-1:0] nkey_r, nkey_nxt;
  logic [LinkW-1:0] cur_r, cur_nxt;
  logic [LinkW-1:0] n_r, n_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic any_r, any_nxt;
  logic tick_r, tick_nxt;

  logic [SW-1:0] rd_addr;
  logic [KeyW-1:0] rd_key;
  logic [LinkW-1:0] rd_next, rd_prev;

  logic key_we, nx_we, pv_we;
  logic [SW-1:0] key_wa, nx_wa, pv_wa;
  logic [KeyW-1:0] key_wd;
  logic [LinkW-1:0] nx_wd, pv_wd;

  logic hd_we, tl_we;
  logic [BW-1:0] hd_wa, tl_wa;
  logic [LinkW-1:0] hd_wd, tl_wd;

  logic ov_nxt;
  out_res_t or_nxt;
  logic ov_r;
  out_res_t or_r;

  function automatic logic [BW-1:0] bsel(input logic [KeyW-1:0] k);
    return BW'(k % NUM_BUCKETS);
  endfunction

  function automatic logic lnk_ok(input logic [LinkW-1:0] l);
    return 32'(l) < NUM_SLOTS;
  endfunction

  always_ff @(posedge clk) begin
    rd_key  <= key_mem[rd_addr];
    rd_next <= next_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    if (key_we) key_mem[key_wa] <= key_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pulse_r  <= '0;
      queued_r <= '0;
      ov_r     <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_r[i] <= NilLink;
        tail_r[i] <= NilLink;
      end
    end else begin
      state_r  <= state_nxt;
      pulse_r  <= pulse_nxt;
      queued_r <= queued_nxt;
      ov_r     <= ov_nxt;
      if (hd_we) head_r[hd_wa] <= hd_wd;
      if (tl_we) tail_r[tl_wa] <= tl_wd;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    nkey_r <= nkey_nxt;
    cur_r  <= cur_nxt;
    n_r    <= n_nxt;
    bkt_r  <= bkt_nxt;
    any_r  <= any_nxt;
    tick_r <= tick_nxt;
    or_r   <= or_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_res = or_r;

  logic [SW-1:0] id_s;
  logic id_ok;
  logic [23:0] dly;
  logic [KeyW-1:0] q_diff;
  assign id_s = req_r.event_id[SW-1:0];
  assign id_ok = 32'(req_r.event_id) < NUM_SLOTS;
  assign dly = (req_r.delay == '0) ? 24'd1 : req_r.delay;
  assign q_diff = rd_key - pulse_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_RD;
      S_RD: begin
        unique case (action_t'(req_r.action))
          ACT_SCHED: begin
            if (!id_ok || queued_r[id_s]) state_nxt = S_DONE;
            else state_nxt = lnk_ok(tail_r[bsel(pulse_r + KeyW'(dly))]) ? S_WALK : S_INS_NRD;
          end
          ACT_CANCEL: state_nxt = (id_ok && queued_r[id_s]) ? S_UNL_RD : S_DONE;
          ACT_QUERY:  state_nxt = S_DONE;
          default:    state_nxt = S_TICK_HD;
        endcase
      end
      S_WALK_RD:  state_nxt = S_WALK;
      S_WALK: begin
        if (key_before(rd_key, nkey_r)) state_nxt = S_INS_NRD;
        else if (lnk_ok(rd_prev)) state_nxt = S_WALK_RD;
        else state_nxt = S_INS_NRD;
      end
      S_INS_NRD:  state_nxt = S_INS_FIX;
      S_INS_FIX:  state_nxt = S_INS_LNK;
      S_INS_LNK:  state_nxt = S_DONE;
      S_UNL_RD:   state_nxt = S_UNL_FIX;
      S_UNL_FIX:  state_nxt = tick_r ? S_TICK_HD : S_DONE;
      S_TICK_HD:  state_nxt = lnk_ok(head_r[bkt_r]) ? S_TICK_KEY : S_IDLE;
      S_TICK_KEY: state_nxt = key_before(pulse_r, rd_key) ? S_IDLE : S_UNL_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pulse_nxt = pulse_r;
    queued_nxt = queued_r;
    req_nxt = req_r;
    nkey_nxt = nkey_r;
    cur_nxt = cur_r;
    n_nxt = n_r;
    bkt_nxt = bkt_r;
    any_nxt = any_r;
    tick_nxt = tick_r;
    rd_addr = id_s;
    key_we = 1'b0; key_wa = id_s; key_wd = nkey_r;
    nx_we = 1'b0; nx_wa = id_s; nx_wd = NilLink;
    pv_we = 1'b0; pv_wa = id_s; pv_wd = NilLink;
    hd_we = 1'b0; hd_wa = bkt_r; hd_wd = NilLink;
    tl_we = 1'b0; tl_wa = bkt_r; tl_wd = NilLink;
    ov_nxt = 1'b0;
    or_nxt = or_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          tick_nxt = 1'b0;
          any_nxt = 1'b0;
        end
      end
      S_RD: begin
        nkey_nxt = pulse_r + KeyW'(dly);
        bkt_nxt = bsel(pulse_r + KeyW'(dly));
        if (action_t'(req_r.action) == ACT_SCHED) begin
          cur_nxt = tail_r[bsel(pulse_r + KeyW'(dly))];
          rd_addr = cur_nxt[SW-1:0];
        end else if (action_t'(req_r.action) == ACT_TICK) begin
          pulse_nxt = pulse_r + 1'b1;
          bkt_nxt = bsel(pulse_r + 1'b1);
          tick_nxt = 1'b1;
        end
      end
      S_WALK_RD: rd_addr = cur_r[SW-1:0];
      S_WALK: begin
        if (!key_before(rd_key, nkey_r)) begin
          cur_nxt = rd_prev;
          rd_addr = rd_prev[SW-1:0];
        end
      end
      S_INS_NRD: begin
        rd_addr = cur_r[SW-1:0];
        if (lnk_ok(cur_r)) n_nxt = NilLink;
        else n_nxt = head_r[bkt_r];
      end
      S_INS_FIX: begin
        if (lnk_ok(cur_r)) n_nxt = rd_next;
        key_we = 1'b1;
        queued_nxt[id_s] = 1'b1;
        pv_we = 1'b1; pv_wd = cur_r;
        nx_we = 1'b1; nx_wd = n_nxt;
        if (!lnk_ok(cur_r)) begin
          hd_we = 1'b1; hd_wd = {1'b0, req_r.event_id};
        end
        if (!lnk_ok(n_nxt)) begin
          tl_we = 1'b1; tl_wd = {1'b0, req_r.event_id};
        end
      end
      S_INS_LNK: begin
        if (lnk_ok(cur_r)) begin
          nx_we = 1'b1; nx_wa = cur_r[SW-1:0]; nx_wd = {1'b0, req_r.event_id};
        end
        if (lnk_ok(n_r)) begin
          pv_we = 1'b1; pv_wa = n_r[SW-1:0]; pv_wd = {1'b0, req_r.event_id};
        end
      end
      S_UNL_RD: rd_addr = cur_r[SW-1:0];
      S_UNL_FIX: begin
        hd_wa = bsel(rd_key);
        tl_wa = bsel(rd_key);
        queued_nxt[cur_r[SW-1:0]] = 1'b0;
        if (!lnk_ok(rd_prev)) begin
          hd_we = 1'b1; hd_wd = rd_next;
        end else begin
          nx_we = 1'b1; nx_wa = rd_prev[SW-1:0]; nx_wd = rd_next;
        end
        if (!lnk_ok(rd_next)) begin
          tl_we = 1'b1; tl_wd = rd_prev;
        end else begin
          pv_we = 1'b1; pv_wa = rd_next[SW-1:0]; pv_wd = rd_prev;
        end
        if (tick_r) begin
          or_nxt = '{kind: KIND_FIRED, fired_id: cur_r[5:0], remaining: '0,
                     status: ST_OK, last: 1'b0};
          any_nxt = 1'b1;
        end
      end
      S_TICK_HD: begin
        cur_nxt = head_r[bkt_r];
        rd_addr = head_r[bkt_r][SW-1:0];
        if (!lnk_ok(head_r[bkt_r])) begin
          ov_nxt = 1'b1;
          if (any_r) begin
            or_nxt = or_r;
            or_nxt.last = 1'b1;
          end else begin
            or_nxt = '{kind: KIND_IDLE, fired_id: '0, remaining: '0,
                       status: ST_OK, last: 1'b1};
          end
        end
      end
      S_TICK_KEY: begin
        rd_addr = cur_r[SW-1:0];
        if (key_before(pulse_r, rd_key)) begin
          ov_nxt = 1'b1;
          if (any_r) begin
            or_nxt = or_r;
            or_nxt.last = 1'b1;
          end else begin
            or_nxt = '{kind: KIND_IDLE, fired_id: '0, remaining: '0,
                       status: ST_OK, last: 1'b1};
          end
        end else if (any_r) begin
          ov_nxt = 1'b1;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        or_nxt = '{kind: KIND_SCHED, fired_id: req_r.event_id, remaining: '0,
                   status: ST_OK, last: 1'b1};
        unique case (action_t'(req_r.action))
          ACT_SCHED: begin
            or_nxt.kind = KIND_SCHED;
            if (!id_ok) or_nxt.status = ST_NOTQ;
            else if (tick_r) or_nxt.status = ST_QUEUED;
          end
          ACT_CANCEL: begin
            or_nxt.kind = KIND_CANCEL;
            if (!tick_r) or_nxt.status = ST_NOTQ;
          end
          default: begin
            or_nxt.kind = KIND_TIME;
            if (!id_ok || !queued_r[id_s]) or_nxt.status = ST_NOTQ;
            else if (q_diff[KeyW-1]) or_nxt.remaining = '0;
            else if (q_diff > 32'hFF_FFFF) or_nxt.remaining = 24'hFF_FFFF;
            else or_nxt.remaining = q_diff[23:0];
          end
        endcase
      end
      default: ;
    endcase
    if (state_r == S_RD && action_t'(req_r.action) == ACT_SCHED && id_ok &&
        queued_r[id_s]) begin
      tick_nxt = 1'b1;
    end
    if (state_r == S_RD && action_t'(req_r.action) == ACT_CANCEL) begin
      cur_nxt = {1'b0, req_r.event_id};
      tick_nxt = 1'b0;
    end
    if (state_r == S_UNL_FIX && !tick_r) tick_nxt = 1'b1;
    if (state_r == S_UNL_FIX && !tick_r &&
        action_t'(req_r.action) == ACT_CANCEL) begin
      tick_nxt = 1'b1;
    end
    if (state_r == S_TICK_KEY && !key_before(pulse_r, rd_key)) tick_nxt = 1'b1;
    if (state_r == S_DONE || state_r == S_TICK_HD) tick_nxt = tick_r;
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy || out_res.last)
    else $error("result outside a request");
  assert property (@(posedge clk) disable iff (!rst_n) (busy && !$past(busy)) |=> busy)
    else $error("request finished too early");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |-> !busy)
    else $error("busy after final result");

endmodule

// ===== dv/tb_hashed_timer_wheel_sorted_buckets.sv =====
`timescale 1ns / 100ps

module tb_hashed_timer_wheel_sorted_buckets;
  import htw_pkg::*;

  localparam int NB = 16;
  localparam int NS = 64;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;

  hashed_timer_wheel_sorted_buckets DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #5 clk = ~clk;

  logic [31:0] pulse;
  logic [31:0] key_of [NS];
  logic        queued [NS];
  logic [6:0]  nxt [NS];
  logic [6:0]  prv [NS];
  logic [6:0]  head [NB];
  logic [6:0]  tail [NB];

  out_res_t expected_results [$];
  int errors = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void push_res(kind_t k, logic [5:0] id, logic [23:0] rem,
                                   status_t st, logic lst);
    out_res_t r;
    r.kind = k; r.fired_id = id; r.remaining = rem; r.status = st; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void unlink_event(int s);
    int b;
    logic [6:0] p, n;
    b = key_of[s] % NB;
    p = prv[s]; n = nxt[s];
    if (p >= NS) head[b] = n; else nxt[p] = n;
    if (n >= NS) tail[b] = p; else prv[n] = p;
    queued[s] = 1'b0;
  endfunction

  function automatic void insert_event(int s, logic [31:0] k);
    int b;
    logic [6:0] i, h, n;
    b = k % NB;
    i = tail[b];
    key_of[s] = k; queued[s] = 1'b1;
    while (i < NS && !earlier(key_of[i], k)) i = prv[i];
    if (i >= NS) begin
      h = head[b];
      prv[s] = NilLink; nxt[s] = h;
      if (h < NS) prv[h] = 7'(s); else tail[b] = 7'(s);
      head[b] = 7'(s);
    end else begin
      n = nxt[i];
      prv[s] = i; nxt[s] = n;
      if (n < NS) prv[n] = 7'(s); else tail[b] = 7'(s);
      nxt[i] = 7'(s);
    end
  endfunction

  function automatic void predict_request(in_req_t r);
    logic [23:0] d;
    logic [31:0] rem;
    logic [6:0] h;
    int b, n;
    out_res_t lr;
    case (action_t'(r.action))
      ACT_SCHED: begin
        if (queued[r.event_id]) push_res(KIND_SCHED, r.event_id, 0, ST_QUEUED, 1'b1);
        else begin
          d = (r.delay == 0) ? 24'd1 : r.delay;
          insert_event(r.event_id, pulse + d);
          push_res(KIND_SCHED, r.event_id, 0, ST_OK, 1'b1);
        end
      end
      ACT_CANCEL: begin
        if (!queued[r.event_id]) push_res(KIND_CANCEL, r.event_id, 0, ST_NOTQ, 1'b1);
        else begin
          unlink_event(r.event_id);
          push_res(KIND_CANCEL, r.event_id, 0, ST_OK, 1'b1);
        end
      end
      ACT_QUERY: begin
        if (!queued[r.event_id]) push_res(KIND_TIME, r.event_id, 0, ST_NOTQ, 1'b1);
        else begin
          rem = key_of[r.event_id] - pulse;
          if (rem[31]) rem = 0;
          else if (rem > 32'hFFFFFF) rem = 32'hFFFFFF;
          push_res(KIND_TIME, r.event_id, rem[23:0], ST_OK, 1'b1);
        end
      end
      default: begin
        n = 0;
        pulse = pulse + 1;
        b = pulse % NB;
        while (n < NS) begin
          h = head[b];
          if (h >= NS) break;
          if (earlier(pulse, key_of[h])) break;
          unlink_event(h);
          push_res(KIND_FIRED, h[5:0], 0, ST_OK, 1'b0);
          n++;
        end
        if (n == 0) push_res(KIND_IDLE, 0, 0, ST_OK, 1'b1);
        else begin
          lr = expected_results.pop_back();
          lr.last = 1'b1;
          expected_results.push_back(lr);
        end
      end
    endcase
  endfunction

  task automatic send_request(action_t a, logic [5:0] id, logic [23:0] d);
    in_req_t r;
    r.action = a; r.event_id = id; r.delay = d;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_res);
        errors++;
      end else begin
        if (out_res !== expected_results[0])
          $display("%0t mismatch expected %p actual %p", $time, expected_results[0], out_res);
        if (out_res !== expected_results[0]) errors++;
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(ACT_CANCEL, 6'd5, 0);
    send_request(ACT_QUERY, 6'd63, 0);
    send_request(ACT_TICK, 0, 0);
    send_request(ACT_SCHED, 6'd0, 24'd0);
    send_request(ACT_SCHED, 6'd0, 24'd4);
    send_request(ACT_SCHED, 6'd63, 24'hFFFFFF);
    send_request(ACT_SCHED, 6'd1, 24'd17);
    send_request(ACT_SCHED, 6'd2, 24'd17);
    send_request(ACT_SCHED, 6'd3, 24'd1);
    send_request(ACT_QUERY, 6'd63, 0);
    send_request(ACT_QUERY, 6'd2, 0);
    send_request(ACT_TICK, 0, 0);
    send_request(ACT_CANCEL, 6'd1, 0);
    send_request(ACT_QUERY, 6'd1, 0);
    repeat (17) send_request(ACT_TICK, 0, 0);
    send_request(ACT_CANCEL, 6'd63, 0);
    wait_drain();
  endtask

  task automatic test_burst_fire();
    for (int i = 0; i < NS; i++)
      send_request(ACT_SCHED, i[5:0], 24'(2 + ($urandom_range(0, 1) * 16)));
    repeat (3) send_request(ACT_TICK, 0, 0);
    repeat (16) send_request(ACT_TICK, 0, 0);
    wait_drain();
  endtask

  task automatic test_random();
    int a;
    for (int i = 0; i < 100; i++) begin
      if (i > 80) allow_gaps = 1'b0;
      a = $urandom_range(0, 9);
      if (a < 4)
        send_request(ACT_SCHED, 6'($urandom_range(0, 63)),
                     ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                                                   24'($urandom_range(0, 40)));
      else if (a < 5) send_request(ACT_CANCEL, 6'($urandom_range(0, 63)), 24'($urandom));
      else if (a < 6) send_request(ACT_QUERY, 6'($urandom_range(0, 63)), 24'($urandom));
      else send_request(ACT_TICK, 6'($urandom_range(0, 63)), 24'($urandom));
    end
    wait_drain();
  endtask

  initial begin
    pulse = 0;
    for (int i = 0; i < NS; i++) begin
      queued[i] = 1'b0; key_of[i] = 0; nxt[i] = NilLink; prv[i] = NilLink;
    end
    for (int i = 0; i < NB; i++) begin
      head[i] = NilLink; tail[i] = NilLink;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_burst_fire();
    test_random();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/htw_pkg.sv
sv/hashed_timer_wheel_sorted_buckets.sv
dv/tb_hashed_timer_wheel_sorted_buckets.sv
